// ----- design/opsl_pkg.sv -----
// ---------------------------------------------------------------------------
// Obstacle proximity speed limiter package
// Shared constants, types and helper functions of the limiter.
// ---------------------------------------------------------------------------
package opsl_pkg;

	localparam int SCAN_LENGTH  = 245;
	localparam int CENTER_INDEX = 122;
	localparam int HALF_WINDOW  = 15;
	localparam int IDX_W        = $clog2(SCAN_LENGTH + 1);

	localparam int CORDIC_STEPS = 16;
	localparam int PRE_SHIFT    = 14;
	localparam logic [34:0] HALF_PI_Q30 = 35'd1686629713;
	localparam logic [24:0] STEP_Q30    = 25'd17602324;

	// The angle never reaches 2^32, so the scan step is estimated from its
	// upper 24 bits times floor(2^34 / STEP_Q30), shifted down by 26. The
	// estimate is exact or one short.
	localparam logic [9:0] ANGLE_RECIP       = 10'd976;
	localparam int         ANGLE_RECIP_SHIFT = 26;

	localparam logic [1:0] CFG_MAX_SPEED = 2'd0;
	localparam logic [1:0] CFG_STOP_DIST = 2'd1;
	localparam logic [1:0] CFG_SLOW_DIST = 2'd2;

	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_BLIND = 3'd1;
	localparam logic [2:0] MODE_FULL  = 3'd2;
	localparam logic [2:0] MODE_SLOW  = 3'd3;
	localparam logic [2:0] MODE_STOP  = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_SUM, ST_CHECK, ST_ROOT_M, ST_ROOT_R,
		ST_CORDIC, ST_ANGLE, ST_ANGLE_DIV, ST_DIR, ST_NORM_MUL, ST_NORM_START,
		ST_NORM_DIV, ST_WALK_RD, ST_WALK_CMP, ST_DECIDE, ST_RAMP_MUL, ST_RAMP_START,
		ST_RAMP_DIV, ST_EMIT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [47:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic        start;
		logic [39:0] dividend;
		logic [24:0] divisor;
	} div_req_t;

	function automatic logic [34:0] atan_q30(input logic [3:0] i);
		logic [34:0] v;
		unique case (i)
			4'd0:  v = 35'd843314856;
			4'd1:  v = 35'd497837829;
			4'd2:  v = 35'd263043836;
			4'd3:  v = 35'd133525158;
			4'd4:  v = 35'd67021686;
			4'd5:  v = 35'd33543515;
			4'd6:  v = 35'd16775850;
			4'd7:  v = 35'd8388437;
			4'd8:  v = 35'd4194282;
			4'd9:  v = 35'd2097149;
			4'd10: v = 35'd1048575;
			4'd11: v = 35'd524287;
			4'd12: v = 35'd262143;
			4'd13: v = 35'd131071;
			4'd14: v = 35'd65535;
			default: v = 35'd32767;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] abs16(input logic signed [15:0] c);
		logic [16:0] w;
		w = c[15] ? 17'(-{c[15], c}) : {1'b0, c};
		return w[15:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic neg, input logic [39:0] q);
		logic signed [15:0] v;
		if (neg) begin
			v = (q > 40'd32768) ? 16'sh8000 : 16'(~q[15:0] + 16'd1);
		end else begin
			v = (q > 40'd32767) ? 16'sh7fff : q[15:0];
		end
		return v;
	endfunction

endpackage

// ----- design/opsl_if.sv -----
// ---------------------------------------------------------------------------
// Limiter channel interfaces
// Request, result and configuration channels with valid and ready.
// ---------------------------------------------------------------------------
interface opsl_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [15:0] cmd_lin_x;
	logic signed [15:0] cmd_lin_y;
	logic signed [15:0] cmd_lin_z;
	logic signed [15:0] cmd_ang_x;
	logic signed [15:0] cmd_ang_y;
	logic signed [15:0] cmd_ang_z;
	logic        [15:0] range_sample;
	logic               scan_end;
	modport source (output valid, req_type, cmd_lin_x, cmd_lin_y, cmd_lin_z, cmd_ang_x,
		cmd_ang_y, cmd_ang_z, range_sample, scan_end, input ready);
	modport sink (input valid, req_type, cmd_lin_x, cmd_lin_y, cmd_lin_z, cmd_ang_x,
		cmd_ang_y, cmd_ang_z, range_sample, scan_end, output ready);
endinterface

interface opsl_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_lin_x;
	logic signed [15:0] out_lin_y;
	logic signed [15:0] out_lin_z;
	logic signed [15:0] out_ang_x;
	logic signed [15:0] out_ang_y;
	logic signed [15:0] out_ang_z;
	logic        [2:0]  limit_mode;
	modport source (output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
		out_ang_z, limit_mode, input ready);
	modport sink (input valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
		out_ang_z, limit_mode, output ready);
endinterface

interface opsl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [15:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ----- design/opsl_isqrt.sv -----
// ---------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 48-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module opsl_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  opsl_pkg::sqrt_req_t req,
	output logic                done,
	output logic [23:0]         root
);
	import opsl_pkg::*;

	logic [47:0] n_q;
	logic [25:0] rem_q;
	logic [23:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [27:0] rem_sh;
	logic [27:0] trial;
	logic        fits;

	assign rem_sh = {rem_q, n_q[47:46]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd23;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q    <= req.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= {n_q[45:0], 2'b00};
			rem_q  <= fits ? 26'(rem_sh - trial) : rem_sh[25:0];
			root_q <= {root_q[22:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- design/opsl_div.sv -----
// ---------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division of a 40-bit dividend by a 25-bit divisor.
// ---------------------------------------------------------------------------
module opsl_div (
	input  logic               clk,
	input  logic               arst_n,
	input  opsl_pkg::div_req_t req,
	output logic               done,
	output logic [39:0]        quotient
);
	import opsl_pkg::*;

	logic [39:0] quo_q;
	logic [24:0] rem_q;
	logic [24:0] dv_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [25:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q, quo_q[39]};
	assign fits   = rem_sh >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd39;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dv_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 25'(rem_sh - {1'b0, dv_q}) : rem_sh[24:0];
			quo_q <= {quo_q[38:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- design/obstacle_proximity_speed_limiter_core.sv -----
// ---------------------------------------------------------------------------
// Obstacle proximity speed limiter core
// Holds the velocity command, stores a laser scan and emits a limited command.
// ---------------------------------------------------------------------------
// A velocity command item only replaces the held command. A range sample
// item is written to the next free entry of the 245-entry scan memory;
// samples beyond that are dropped. The sample that closes a scan starts the
// evaluation, during which the request channel is not ready. The evaluation
// runs on one shared multiplier, one bit-serial square-root unit, one
// restoring divider and one CORDIC stage reused for 16 iterations. The angle
// is turned into a scan step by a constant reciprocal multiplication and one
// correction step. A command with no linear motion skips the evaluation and
// is emitted directly. Otherwise the closing item goes through the magnitude,
// angle and normalisation, then, unless the direction falls outside the scan,
// a walk over the window of up to 29 scan entries around the direction of
// travel; in the slowing zone three ramp divisions follow. The result sits in
// an output register, so a pending result only holds up the next closing
// item, never command or sample items.
module obstacle_proximity_speed_limiter_core (
	input  logic clk,
	input  logic arst_n,
	opsl_req_if.sink   req,
	opsl_rsp_if.source rsp,
	opsl_cfg_if.sink   cfg
);
	import opsl_pkg::*;

	state_t state_q, state_d;

	// Configuration registers.
	logic [14:0] max_speed_q;
	logic [15:0] stop_q, slow_q;

	// Held command and scan fill position.
	logic signed [15:0] held_lin_q [3];
	logic signed [15:0] held_ang_q [3];
	logic [IDX_W-1:0]   pos_q;

	// Scan memory.
	logic [15:0] mem [SCAN_LENGTH];
	logic [15:0] rd_q;

	// Shared arithmetic.
	logic [15:0] mul_a;
	logic [23:0] mul_b;
	logic [39:0] p_q;
	sqrt_req_t   sqrt_req;
	logic        sqrt_done;
	logic [23:0] sqrt_root;
	div_req_t    div_req;
	logic        div_done;
	logic [39:0] div_quo;

	// Evaluation registers.
	logic [31:0]        s2_q, yz_q;
	logic [23:0]        m8_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [34:0] acc_q;
	logic [3:0]         cnt_q;
	logic [8:0]         k_q;
	logic               blind_q;
	logic [IDX_W-1:0]   idx_q, hi_q;
	logic [15:0]        d_q;
	logic [1:0]         j_q;
	logic signed [15:0] lin_q [3];
	logic [2:0]         mode_q;

	// Output register.
	logic               out_valid_q;
	logic signed [15:0] out_lin_q [3];
	logic signed [15:0] out_ang_q [3];
	logic [2:0]         out_mode_q;

	logic req_fire, emit_fire;
	logic signed [15:0] cur_c;
	logic signed [33:0] xs, ys;
	logic signed [10:0] dir;
	logic [34:0]        theta;
	logic [33:0]        angle_prod;
	logic [34:0]        angle_rem;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	assign cur_c = held_lin_q[j_q];
	assign xs    = cx_q >>> cnt_q;
	assign ys    = cy_q >>> cnt_q;
	assign dir   = held_lin_q[1][15] ? 11'(CENTER_INDEX) - 11'(k_q)
		: 11'(CENTER_INDEX) + 11'(k_q);
	assign theta = acc_q[34] ? '0 : acc_q;

	// Scan step estimate and the remainder that tells whether it is one short.
	assign angle_prod = 34'(theta[31:8]) * 34'(ANGLE_RECIP);
	assign angle_rem  = theta - 35'(k_q) * 35'(STEP_Q30);

	opsl_isqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .done(sqrt_done),
		.root(sqrt_root));
	opsl_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .done(div_done),
		.quotient(div_quo));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (req_fire && req.req_type && req.scan_end) state_d = ST_SQ_X;
			ST_SQ_X:       state_d = ST_SQ_Y;
			ST_SQ_Y:       state_d = ST_SQ_Z;
			ST_SQ_Z:       state_d = ST_SQ_SUM;
			ST_SQ_SUM:     state_d = ST_CHECK;
			ST_CHECK:      state_d = (s2_q == '0) ? ST_EMIT : ST_ROOT_M;
			ST_ROOT_M:     if (sqrt_done) state_d = ST_ROOT_R;
			ST_ROOT_R:     if (sqrt_done) state_d = ST_CORDIC;
			ST_CORDIC:     if (cnt_q == 4'(CORDIC_STEPS - 1)) state_d = ST_ANGLE;
			ST_ANGLE:      state_d = ST_ANGLE_DIV;
			ST_ANGLE_DIV:  state_d = ST_DIR;
			ST_DIR:        state_d = ST_NORM_MUL;
			ST_NORM_MUL:   state_d = ST_NORM_START;
			ST_NORM_START: state_d = ST_NORM_DIV;
			ST_NORM_DIV: begin
				if (div_done) begin
					if (j_q != 2'd2) state_d = ST_NORM_MUL;
					else state_d = blind_q ? ST_EMIT : ST_WALK_RD;
				end
			end
			ST_WALK_RD:    state_d = ST_WALK_CMP;
			ST_WALK_CMP:   state_d = (idx_q == hi_q) ? ST_DECIDE : ST_WALK_RD;
			ST_DECIDE: begin
				if (d_q < stop_q || d_q >= slow_q) state_d = ST_EMIT;
				else state_d = ST_RAMP_MUL;
			end
			ST_RAMP_MUL:   state_d = ST_RAMP_START;
			ST_RAMP_START: state_d = ST_RAMP_DIV;
			ST_RAMP_DIV:   if (div_done) state_d = (j_q == 2'd2) ? ST_EMIT : ST_RAMP_MUL;
			ST_EMIT:       if (emit_fire) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Operand selection for the shared units.
	always_comb begin
		mul_a    = abs16(cur_c);
		mul_b    = 24'(abs16(cur_c));
		sqrt_req = '0;
		div_req  = '0;
		unique case (state_q)
			ST_SQ_X: begin
				mul_a = abs16(held_lin_q[0]);
				mul_b = 24'(abs16(held_lin_q[0]));
			end
			ST_SQ_Y: begin
				mul_a = abs16(held_lin_q[1]);
				mul_b = 24'(abs16(held_lin_q[1]));
			end
			ST_SQ_Z: begin
				mul_a = abs16(held_lin_q[2]);
				mul_b = 24'(abs16(held_lin_q[2]));
			end
			ST_CHECK: begin
				sqrt_req.start    = (s2_q != '0);
				sqrt_req.radicand = {s2_q, 16'd0};
			end
			ST_ROOT_M: begin
				sqrt_req.start    = sqrt_done;
				sqrt_req.radicand = {16'd0, yz_q};
			end
			ST_NORM_MUL:   mul_b = {1'b0, max_speed_q, 8'd0};
			ST_NORM_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = p_q;
				div_req.divisor  = {1'b0, m8_q};
			end
			ST_RAMP_MUL:   mul_b = 24'(d_q - stop_q);
			ST_RAMP_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = p_q;
				div_req.divisor  = 25'(slow_q - stop_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_speed_q <= 15'd2048;
			stop_q      <= 16'd77;
			slow_q      <= 16'd538;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				held_lin_q[i] <= '0;
				held_ang_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg.addr)
					CFG_MAX_SPEED: max_speed_q <= cfg.data[14:0];
					CFG_STOP_DIST: stop_q      <= cfg.data;
					CFG_SLOW_DIST: slow_q      <= cfg.data;
					default: ;
				endcase
			end
			if (req_fire) begin
				if (!req.req_type) begin
					held_lin_q[0] <= req.cmd_lin_x;
					held_lin_q[1] <= req.cmd_lin_y;
					held_lin_q[2] <= req.cmd_lin_z;
					held_ang_q[0] <= req.cmd_ang_x;
					held_ang_q[1] <= req.cmd_ang_y;
					held_ang_q[2] <= req.cmd_ang_z;
				end else if (req.scan_end) begin
					pos_q <= '0;
				end else if (pos_q < IDX_W'(SCAN_LENGTH)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (emit_fire) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// Scan memory: written by sample items, read during the window walk.
	always_ff @(posedge clk) begin
		if (req_fire && req.req_type && pos_q < IDX_W'(SCAN_LENGTH)) begin
			mem[pos_q] <= req.range_sample;
		end
		if (state_q == ST_WALK_RD) rd_q <= mem[idx_q];
	end

	// Evaluation datapath.
	always_ff @(posedge clk) begin
		p_q <= 40'(mul_a) * 40'(mul_b);
		unique case (state_q)
			ST_SQ_Y:   s2_q <= p_q[31:0];
			ST_SQ_Z: begin
				s2_q <= s2_q + p_q[31:0];
				yz_q <= p_q[31:0];
			end
			ST_SQ_SUM: begin
				s2_q <= s2_q + p_q[31:0];
				yz_q <= yz_q + p_q[31:0];
			end
			ST_CHECK: begin
				mode_q <= MODE_IDLE;
				for (int i = 0; i < 3; i++) lin_q[i] <= held_lin_q[i];
			end
			ST_ROOT_M: if (sqrt_done) m8_q <= sqrt_root;
			ST_ROOT_R: begin
				if (sqrt_done) begin
					cnt_q <= '0;
					if (!held_lin_q[0][15]) begin
						cx_q  <= 34'(held_lin_q[0]) <<< PRE_SHIFT;
						cy_q  <= 34'(sqrt_root[15:0]) << PRE_SHIFT;
						acc_q <= '0;
					end else begin
						cx_q  <= 34'(sqrt_root[15:0]) << PRE_SHIFT;
						cy_q  <= 34'(abs16(held_lin_q[0])) << PRE_SHIFT;
						acc_q <= HALF_PI_Q30;
					end
				end
			end
			ST_CORDIC: begin
				cnt_q <= cnt_q + 4'd1;
				if (cy_q > 0) begin
					cx_q  <= cx_q + ys;
					cy_q  <= cy_q - xs;
					acc_q <= acc_q + atan_q30(cnt_q);
				end else if (cy_q < 0) begin
					cx_q  <= cx_q - ys;
					cy_q  <= cy_q + xs;
					acc_q <= acc_q - atan_q30(cnt_q);
				end
			end
			ST_ANGLE:     k_q <= 9'(angle_prod >> ANGLE_RECIP_SHIFT);
			ST_ANGLE_DIV: if (angle_rem >= 35'(STEP_Q30)) k_q <= k_q + 9'd1;
			ST_DIR: begin
				j_q     <= '0;
				blind_q <= dir[10] || dir >= 11'(SCAN_LENGTH);
				mode_q  <= MODE_BLIND;
				idx_q   <= (dir < 11'(HALF_WINDOW - 1)) ? '0
					: IDX_W'(dir - 11'(HALF_WINDOW - 1));
				hi_q    <= (dir + 11'(HALF_WINDOW - 1) > 11'(SCAN_LENGTH - 1))
					? IDX_W'(SCAN_LENGTH - 1) : IDX_W'(dir + 11'(HALF_WINDOW - 1));
				d_q     <= 16'hffff;
			end
			ST_NORM_DIV: begin
				if (div_done) begin
					lin_q[j_q] <= sat16(cur_c[15], div_quo);
					j_q        <= j_q + 2'd1;
				end
			end
			ST_WALK_CMP: begin
				if (rd_q < d_q) d_q <= rd_q;
				idx_q <= idx_q + 1'b1;
			end
			ST_DECIDE: begin
				j_q <= '0;
				if (d_q < stop_q) begin
					mode_q <= MODE_STOP;
					for (int i = 0; i < 3; i++) lin_q[i] <= '0;
				end else if (d_q < slow_q) begin
					mode_q <= MODE_SLOW;
				end else begin
					mode_q <= MODE_FULL;
				end
			end
			ST_RAMP_DIV: begin
				if (div_done) begin
					lin_q[j_q] <= sat16(cur_c[15], div_quo);
					j_q        <= j_q + 2'd1;
				end
			end
			default: ;
		endcase
		if (emit_fire) begin
			for (int i = 0; i < 3; i++) begin
				out_lin_q[i] <= lin_q[i];
				out_ang_q[i] <= held_ang_q[i];
			end
			out_mode_q <= mode_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_lin_x  = out_lin_q[0];
	assign rsp.out_lin_y  = out_lin_q[1];
	assign rsp.out_lin_z  = out_lin_q[2];
	assign rsp.out_ang_x  = out_ang_q[0];
	assign rsp.out_ang_y  = out_ang_q[1];
	assign rsp.out_ang_z  = out_ang_q[2];
	assign rsp.limit_mode = out_mode_q;

	// The fill position never runs past the end of the scan memory.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= IDX_W'(SCAN_LENGTH))
		else $error("scan fill position beyond memory");

	// The window walk never reads past its upper bound.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK_CMP |-> idx_q <= hi_q)
		else $error("window walk beyond upper bound");

	// A stopped result carries no linear motion.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire && mode_q == MODE_STOP |=> rsp.out_lin_x == 0 && rsp.out_lin_y == 0
		&& rsp.out_lin_z == 0)
		else $error("stopped result with linear motion");

	// No request item is taken while the evaluation is running.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !req.ready)
		else $error("request accepted during evaluation");

endmodule

// ----- test/opsl_speed_checker.sv -----
// ---------------------------------------------------------------------------
// Speed limiter result checker
// Watches the limiter's channels, predicts each limited command and compares.
// ---------------------------------------------------------------------------
module opsl_speed_checker (
	input  logic  clk,
	input  logic  arst_n,
	opsl_req_if   req,
	opsl_rsp_if   rsp,
	opsl_cfg_if   cfg,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import opsl_pkg::*;

	typedef struct packed {
		logic signed [15:0] lin_x;
		logic signed [15:0] lin_y;
		logic signed [15:0] lin_z;
		logic signed [15:0] ang_x;
		logic signed [15:0] ang_y;
		logic signed [15:0] ang_z;
		logic        [2:0]  mode;
	} limited_cmd_t;

	localparam longint ARC_STEP[16] = '{843314856, 497837829, 263043836, 133525158,
		67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767};

	logic [15:0]        scan_ranges [SCAN_LENGTH];
	int                 fill_pos;
	logic signed [15:0] lin_hold [3];
	logic signed [15:0] ang_hold [3];
	logic [14:0]        speed_max;
	logic [15:0]        stop_limit;
	logic [15:0]        slow_limit;
	limited_cmd_t       awaited_cmds [$];

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint heading_angle(longint x, longint r);
		longint ax, ay, acc, nx;
		if (x >= 0) begin
			ax = x <<< PRE_SHIFT;
			ay = r <<< PRE_SHIFT;
			acc = 0;
		end else begin
			ax = r <<< PRE_SHIFT;
			ay = (-x) <<< PRE_SHIFT;
			acc = longint'(HALF_PI_Q30);
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (ay > 0) begin
				nx = ax + (ay >>> i);
				ay = ay - (ax >>> i);
				ax = nx;
				acc += ARC_STEP[i];
			end else if (ay < 0) begin
				nx = ax - (ay >>> i);
				ay = ay + (ax >>> i);
				ax = nx;
				acc -= ARC_STEP[i];
			end
		end
		return (acc < 0) ? 0 : acc;
	endfunction

	function automatic logic signed [15:0] scaled_speed(longint c, longint mul, longint div);
		longint q;
		q = ((c < 0) ? -c : c) * mul / div;
		if (c < 0) q = -q;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return 16'(q);
	endfunction

	function automatic limited_cmd_t limit_command();
		limited_cmd_t res;
		longint x, y, z, s2, mag, r, k, dir, d;
		x = lin_hold[0];
		y = lin_hold[1];
		z = lin_hold[2];
		res.lin_x = lin_hold[0];
		res.lin_y = lin_hold[1];
		res.lin_z = lin_hold[2];
		res.ang_x = ang_hold[0];
		res.ang_y = ang_hold[1];
		res.ang_z = ang_hold[2];
		s2 = x * x + y * y + z * z;
		if (s2 == 0) begin
			res.mode = MODE_IDLE;
			return res;
		end
		mag = int_root(s2 << 16);
		r = int_root(y * y + z * z);
		k = heading_angle(x, r) / longint'(STEP_Q30);
		dir = (y < 0) ? CENTER_INDEX - k : CENTER_INDEX + k;
		res.lin_x = scaled_speed(x, longint'(speed_max) * 256, mag);
		res.lin_y = scaled_speed(y, longint'(speed_max) * 256, mag);
		res.lin_z = scaled_speed(z, longint'(speed_max) * 256, mag);
		if (dir < 0 || dir >= SCAN_LENGTH) begin
			res.mode = MODE_BLIND;
			return res;
		end
		d = 65535;
		for (longint i = dir - HALF_WINDOW + 1; i <= dir + HALF_WINDOW - 1; i++)
			if (i >= 0 && i < SCAN_LENGTH && scan_ranges[i] < d) d = scan_ranges[i];
		if (d < stop_limit) begin
			res.mode = MODE_STOP;
			res.lin_x = '0;
			res.lin_y = '0;
			res.lin_z = '0;
		end else if (d < slow_limit) begin
			res.mode = MODE_SLOW;
			res.lin_x = scaled_speed(x, d - stop_limit, slow_limit - stop_limit);
			res.lin_y = scaled_speed(y, d - stop_limit, slow_limit - stop_limit);
			res.lin_z = scaled_speed(z, d - stop_limit, slow_limit - stop_limit);
		end else begin
			res.mode = MODE_FULL;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		limited_cmd_t want, got;
		if (!arst_n) begin
			fill_pos = 0;
			lin_hold = '{default: '0};
			ang_hold = '{default: '0};
			speed_max = 15'd2048;
			stop_limit = 16'd77;
			slow_limit = 16'd538;
			fail_count = 0;
			awaited_cmds.delete();
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					CFG_MAX_SPEED: speed_max = cfg.data[14:0];
					CFG_STOP_DIST: stop_limit = cfg.data;
					CFG_SLOW_DIST: slow_limit = cfg.data;
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				if (req.req_type == 1'b0) begin
					lin_hold = '{req.cmd_lin_x, req.cmd_lin_y, req.cmd_lin_z};
					ang_hold = '{req.cmd_ang_x, req.cmd_ang_y, req.cmd_ang_z};
				end else begin
					if (fill_pos < SCAN_LENGTH) begin
						scan_ranges[fill_pos] = req.range_sample;
						fill_pos++;
					end
					if (req.scan_end) begin
						fill_pos = 0;
						awaited_cmds.push_back(limit_command());
					end
				end
			end
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.out_lin_x, rsp.out_lin_y, rsp.out_lin_z, rsp.out_ang_x,
					rsp.out_ang_y, rsp.out_ang_z, rsp.limit_mode};
				if (awaited_cmds.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Unexpected result item: lin %0d %0d %0d mode %0d",
							got.lin_x, got.lin_y, got.lin_z, got.mode);
				end else begin
					want = awaited_cmds.pop_front();
					if (got.lin_x !== want.lin_x || got.lin_y !== want.lin_y ||
						got.lin_z !== want.lin_z || got.ang_x !== want.ang_x ||
						got.ang_y !== want.ang_y || got.ang_z !== want.ang_z ||
						got.mode !== want.mode) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"Mismatch: expected lin %0d %0d %0d ang %0d %0d %0d ",
								"mode %0d, got lin %0d %0d %0d ang %0d %0d %0d mode %0d"},
								want.lin_x, want.lin_y, want.lin_z, want.ang_x,
								want.ang_y, want.ang_z, want.mode, got.lin_x, got.lin_y,
								got.lin_z, got.ang_x, got.ang_y, got.ang_z, got.mode);
					end
				end
			end
			pending = awaited_cmds.size();
		end
	end

endmodule

// ----- test/obstacle_proximity_speed_limiter_core_tb.sv -----
// ---------------------------------------------------------------------------
// Speed limiter core testbench
// Drives commands, scans and register writes under varied flow control.
// ---------------------------------------------------------------------------
module obstacle_proximity_speed_limiter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import opsl_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int SETTLE       = 700;
	localparam int PHASE_ITEMS  = 250;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles;
	int   send_idle_pct;
	int   take_stall_pct;
	int   phase_items;
	logic [15:0] cur_slow;

	opsl_req_if req_ch();
	opsl_rsp_if rsp_ch();
	opsl_cfg_if cfg_ch();

	obstacle_proximity_speed_limiter_core dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
	);

	opsl_speed_checker checker_inst (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// The watchdog covers the worst case generously: each closing sample
	// starts a long evaluation and stalls can stretch that further.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The result side stalls at the rate of the current phase. Ready only
	// ever changes at the falling edge, so the block sees a settled value.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= take_stall_pct);
	end

	// One request item: idle gaps first, then the item is held until the
	// block takes it. Valid is only lowered when a gap actually follows, so
	// back-to-back items keep it high throughout.
	task automatic send_item(input logic kind, input logic signed [15:0] lx, ly, lz,
		input logic signed [15:0] ax, ay, az, input logic [15:0] rng, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.cmd_lin_x <= lx;
		req_ch.cmd_lin_y <= ly;
		req_ch.cmd_lin_z <= lz;
		req_ch.cmd_ang_x <= ax;
		req_ch.cmd_ang_y <= ay;
		req_ch.cmd_ang_z <= az;
		req_ch.range_sample <= rng;
		req_ch.scan_end <= last;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		phase_items++;
	endtask

	task automatic send_cmd(input logic signed [15:0] lx, ly, lz, ax, ay, az);
		send_item(1'b0, lx, ly, lz, ax, ay, az, 16'($urandom), 1'($urandom));
	endtask

	// Sample items carry junk in the command fields, which the block ignores.
	task automatic send_sample(input logic [15:0] rng, input logic last);
		send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), rng, last);
	endtask

	task automatic send_scan(input int len);
		for (int i = 0; i < len; i++) send_sample(pick_range(), i == len - 1);
	endtask

	// Registers are only touched once every awaited result has arrived and
	// the block has had time to wind down.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_speed();
		case ($urandom_range(7))
			0: return 16'sd0;
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3, 4, 5: return 16'($signed($urandom_range(16384)) - 8192);
			default: return 16'($urandom);
		endcase
	endfunction

	// Ranges cluster around the stop and slow thresholds so that all the
	// limiting zones are reached, with the extremes mixed in.
	function automatic logic [15:0] pick_range();
		int hi;
		hi = (cur_slow * 2 + 64 > 65535) ? 65535 : cur_slow * 2 + 64;
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hffff;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(hi));
		endcase
	endfunction

	initial begin
		logic [14:0] speeds [5];
		logic [15:0] stops  [5];
		logic [15:0] slows  [5];
		int idle_set [4][2];
		int len;
		speeds = '{15'd2048, 15'd32767, 15'd0, 15'd4096, 15'd1};
		stops = '{16'd77, 16'd0, 16'd65535, 16'd200, 16'd0};
		slows = '{16'd538, 16'd65535, 16'd0, 16'd1500, 16'd1};
		idle_set = '{'{0, 0}, '{54, 0}, '{0, 54}, '{14, 14}};
		cycles = 0;
		send_idle_pct = 0;
		take_stall_pct = 0;
		cur_slow = 16'd538;
		req_ch.valid = 1'b0;
		req_ch.req_type = 1'b0;
		req_ch.cmd_lin_x = '0;
		req_ch.cmd_lin_y = '0;
		req_ch.cmd_lin_z = '0;
		req_ch.cmd_ang_x = '0;
		req_ch.cmd_ang_y = '0;
		req_ch.cmd_ang_z = '0;
		req_ch.range_sample = '0;
		req_ch.scan_end = 1'b0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = CFG_MAX_SPEED;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The first scan fills every entry and runs past the end, so no later
		// window can read an entry that was never written. The held command is
		// still zero, so this closes with no motion.
		send_scan(SCAN_LENGTH + 5);

		// Directed items: extreme commands in the main directions.
		send_cmd(16'sh7fff, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_scan(3);
		send_cmd(16'sh8000, 16'sd0, 16'sd0, 16'sh8000, 16'sh7fff, 16'sd0);
		send_sample(16'd0, 1'b1);
		send_cmd(16'sd0, 16'sh8000, 16'sd0, 16'sd1, 16'sd0, 16'sh8000);
		send_sample(16'hffff, 1'b1);
		send_cmd(16'sd100, 16'sd4096, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
		send_sample(16'd300, 1'b1);
		send_cmd(16'sh8000, 16'sh8000, 16'sh8000, 16'sd7, 16'sd8, 16'sd9);
		send_sample(16'd60, 1'b1);
		send_cmd(16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd4, 16'sd5);
		send_sample(16'd1, 1'b1);
		send_cmd(16'sd4096, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_scan(4);

		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				wait_idle();
				write_reg(CFG_MAX_SPEED, {1'b0, speeds[phase]});
				write_reg(CFG_STOP_DIST, stops[phase]);
				write_reg(CFG_SLOW_DIST, slows[phase]);
				cur_slow = slows[phase];
			end
			send_idle_pct = idle_set[phase % 4][0];
			take_stall_pct = idle_set[phase % 4][1];
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				case ($urandom_range(11))
					0: len = SCAN_LENGTH + $urandom_range(6) - 3;
					1: len = 0;
					default: len = $urandom_range(1, 30);
				endcase
				// Mostly a command followed by a scan, sometimes a lone command
				// or a scan with the previous command still held.
				if ($urandom_range(5) != 0)
					send_cmd(pick_speed(), pick_speed(), pick_speed(),
						16'($urandom), 16'($urandom), 16'($urandom));
				if (len > 0) send_scan(len);
			end
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
